>>> rtl/core/assert_macros.svh
// Concurrent assertion helpers, clocked on the rising edge, masked while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante in one cycle implies cons in the next one
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// expr never holds
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

>>> rtl/core/tts_pkg.sv
`timescale 1ns / 1ps

package tts_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = 6;
   localparam int ROW_W       = 7;
   localparam int DIV_ITERS   = 14;   // two quotient bits per iteration

   localparam logic [31:0] DEF_NAN  = 32'hFFC0_0000;
   localparam logic [31:0] QNAN_BIT = 32'h0040_0000;

   typedef struct packed {
      logic              backward;
      logic              bypass;
      logic              div_start;
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
   } lane_ctrl_type;

   // exp is a biased exponent read as signed; subnormals are normalized
   typedef struct packed {
      logic        sgn;
      logic        zero;
      logic        inf;
      logic        nan;
      logic [11:0] exp;
      logic [23:0] mant;
   } fp_unpacked_type;

   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] n;
      logic       hit;
      n   = 5'd0;
      hit = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (!hit) begin
            if (v[i]) hit = 1'b1;
            else      n   = n + 5'd1;
         end
      end
      return n;
   endfunction

   function automatic logic [4:0] lzc28(input logic [27:0] v);
      logic [4:0] n;
      logic       hit;
      n   = 5'd0;
      hit = 1'b0;
      for (int i = 27; i >= 0; i--) begin
         if (!hit) begin
            if (v[i]) hit = 1'b1;
            else      n   = n + 5'd1;
         end
      end
      return n;
   endfunction

   function automatic fp_unpacked_type fp_unpack(input logic [31:0] x);
      fp_unpacked_type u;
      logic [4:0]      lz;
      u.sgn  = x[31];
      u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
      u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
      u.zero = (x[30:0] == 31'd0);
      lz     = lzc24({1'b0, x[22:0]});
      if (x[30:23] != 8'd0) begin
         u.exp  = {4'd0, x[30:23]};
         u.mant = {1'b1, x[22:0]};
      end else begin
         u.exp  = 12'd1 - {7'd0, lz};
         u.mant = {1'b0, x[22:0]} << lz;
      end
      return u;
   endfunction

   // m[26] is the leading one, m[0] carries sticky; value m/2^26 * 2^(e-127)
   function automatic logic [31:0] fp_round_pack(input logic s, input logic [11:0] e,
                                                 input logic [26:0] m);
      logic [11:0] d;
      logic [4:0]  sh;
      logic [53:0] w;
      logic [26:0] mm;
      logic [7:0]  ee;
      logic [31:0] mag;
      logic        rnd;
      if ($signed(e) > 12'sd254) return {s, 8'hFF, 23'd0};
      if ($signed(e) < 12'sd1) begin
         d  = 12'd1 - e;
         sh = (d > 12'd27) ? 5'd27 : d[4:0];
         ee = 8'd1;
      end else begin
         d  = 12'd0;
         sh = d[4:0];
         ee = e[7:0];
      end
      w   = {m, 27'd0} >> sh;
      mm  = w[53:27];
      rnd = mm[2] & (mm[3] | mm[1] | mm[0] | (|w[26:0]));
      mag = (({24'd0, ee} - 32'd1) << 23) + {8'd0, mm[26:3]} + {31'd0, rnd};
      return {s, mag[30:0]};
   endfunction

endpackage

>>> rtl/core/tts_fdiv.sv
`timescale 1ns / 1ps

module tts_fdiv (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [31:0] quot
);

   tts_pkg::fp_unpacked_type ua, ub;
   logic        spec;
   logic [31:0] spec_val;
   logic        busy_ff, fin_ff, done_ff;
   logic [3:0]  cnt_ff;
   logic [25:0] r_ff, r_in;
   logic [27:0] quo_ff, quo_in;
   logic [11:0] e_ff;
   logic        sgn_ff, spec_ff;
   logic [31:0] spec_val_ff, quot_ff, quot_in;
   logic [23:0] mb_ff;
   logic        ge1, ge2;
   logic [25:0] r1, r1s, r2;
   logic [26:0] mfin;
   logic        stick;

   always_comb begin
      ua = tts_pkg::fp_unpack(num);
      ub = tts_pkg::fp_unpack(den);
      spec     = 1'b1;
      spec_val = {ua.sgn ^ ub.sgn, 31'd0};
      if (ua.nan)                                       spec_val = num | tts_pkg::QNAN_BIT;
      else if (ub.nan)                                  spec_val = den | tts_pkg::QNAN_BIT;
      else if ((ua.inf && ub.inf) || (ua.zero && ub.zero)) spec_val = tts_pkg::DEF_NAN;
      else if (ua.inf || ub.zero) spec_val = {ua.sgn ^ ub.sgn, 8'hFF, 23'd0};
      else if (ua.zero || ub.inf) spec_val = {ua.sgn ^ ub.sgn, 31'd0};
      else                        spec     = 1'b0;
   end

   // restoring division, two quotient bits a cycle
   always_comb begin
      ge1    = r_ff >= {2'd0, mb_ff};
      r1     = ge1 ? r_ff - {2'd0, mb_ff} : r_ff;
      r1s    = {r1[24:0], 1'b0};
      ge2    = r1s >= {2'd0, mb_ff};
      r2     = ge2 ? r1s - {2'd0, mb_ff} : r1s;
      r_in   = {r2[24:0], 1'b0};
      quo_in = {quo_ff[25:0], ge1, ge2};
   end

   always_comb begin
      stick = (r_ff != 26'd0);
      if (quo_ff[27]) begin
         mfin    = quo_ff[27:1] | {26'd0, quo_ff[0] | stick};
         quot_in = tts_pkg::fp_round_pack(sgn_ff, e_ff, mfin);
      end else begin
         mfin    = quo_ff[26:0] | {26'd0, stick};
         quot_in = tts_pkg::fp_round_pack(sgn_ff, e_ff - 12'd1, mfin);
      end
      if (spec_ff) quot_in = spec_val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 4'(tts_pkg::DIV_ITERS - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         r_ff        <= {2'd0, ua.mant};
         quo_ff      <= 28'd0;
         e_ff        <= ua.exp - ub.exp + 12'd127;
         sgn_ff      <= ua.sgn ^ ub.sgn;
         mb_ff       <= ub.mant;
         spec_ff     <= spec;
         spec_val_ff <= spec_val;
      end else if (busy_ff) begin
         r_ff   <= r_in;
         quo_ff <= quo_in;
      end
      if (fin_ff) quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> rtl/core/tts_lane.sv
`timescale 1ns / 1ps

module tts_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  tts_pkg::lane_ctrl_type ctrl,
   input  logic [31:0]           mul_x,
   input  logic [31:0]           minuend,
   input  logic [31:0]           div_num,
   input  logic [31:0]           divisor,
   output logic [31:0]           rd_data,
   output logic [31:0]           s_out,
   output logic                  div_done
);

   function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
      tts_pkg::fp_unpacked_type ua, ub, ubig, usml;
      logic        sb, swap, sg;
      logic [11:0] d, e;
      logic [4:0]  sh, lz;
      logic [53:0] w;
      logic [26:0] al, m;
      logic [27:0] xb, sum, nrm;
      ua = tts_pkg::fp_unpack(a);
      ub = tts_pkg::fp_unpack(b);
      sb = ~b[31];
      if (ua.nan) return a | tts_pkg::QNAN_BIT;
      if (ub.nan) return b | tts_pkg::QNAN_BIT;
      if (ua.inf && ub.inf) return (ua.sgn != sb) ? tts_pkg::DEF_NAN : a;
      if (ua.inf) return a;
      if (ub.inf) return {sb, b[30:0]};
      if (ua.zero && ub.zero) return {ua.sgn & sb, 31'd0};
      if (ua.zero) return {sb, b[30:0]};
      if (ub.zero) return a;
      swap = ($signed(ub.exp) > $signed(ua.exp)) ||
             ((ub.exp == ua.exp) && (ub.mant > ua.mant));
      ubig = swap ? ub : ua;
      usml = swap ? ua : ub;
      sg   = swap ? sb : ua.sgn;
      d    = ubig.exp - usml.exp;
      sh   = (d > 12'd27) ? 5'd27 : d[4:0];
      w    = {usml.mant, 3'd0, 27'd0} >> sh;
      al   = w[53:27] | {26'd0, |w[26:0]};
      xb   = {1'b0, ubig.mant, 3'd0};
      sum  = (ua.sgn == sb) ? xb + {1'b0, al} : xb - {1'b0, al};
      if (sum == 28'd0) return 32'd0;
      if (sum[27]) begin
         m = sum[27:1] | {26'd0, sum[0]};
         e = ubig.exp + 12'd1;
      end else begin
         lz  = tts_pkg::lzc28(sum);
         nrm = sum << (lz - 5'd1);
         m   = nrm[26:0];
         e   = ubig.exp - {7'd0, lz} + 12'd1;
      end
      return tts_pkg::fp_round_pack(sg, e, m);
   endfunction

   logic [31:0] mem [tts_pkg::STORE_DEPTH];
   logic [31:0] rd_ff, prev_ff, wdata;
   logic [31:0] op1, op2;
   tts_pkg::fp_unpacked_type mua, mub;
   logic        m1_spec, m1_spec_ff;
   logic [31:0] m1_val, m1_val_ff;
   logic [47:0] m1_p_ff;
   logic [11:0] m1_e_ff;
   logic        m1_s_ff;
   logic [31:0] m2_in, m2_ff, s_in, s_ff, q;
   logic [26:0] m2_m;

   // multiply, stage one: unpack and raw product
   always_comb begin
      op1 = ctrl.backward ? mul_x : prev_ff;
      op2 = ctrl.backward ? prev_ff : mul_x;
      mua = tts_pkg::fp_unpack(op1);
      mub = tts_pkg::fp_unpack(op2);
      m1_spec = 1'b1;
      m1_val  = {op1[31] ^ op2[31], 31'd0};
      if (mua.nan)      m1_val = op1 | tts_pkg::QNAN_BIT;
      else if (mub.nan) m1_val = op2 | tts_pkg::QNAN_BIT;
      else if ((mua.inf && mub.zero) || (mua.zero && mub.inf)) m1_val = tts_pkg::DEF_NAN;
      else if (mua.inf || mub.inf) m1_val = {op1[31] ^ op2[31], 8'hFF, 23'd0};
      else if (mua.zero || mub.zero) m1_val = {op1[31] ^ op2[31], 31'd0};
      else m1_spec = 1'b0;
   end

   // multiply, stage two: normalize and round
   always_comb begin
      if (m1_p_ff[47]) begin
         m2_m  = m1_p_ff[47:21] | {26'd0, |m1_p_ff[20:0]};
         m2_in = tts_pkg::fp_round_pack(m1_s_ff, m1_e_ff + 12'd1, m2_m);
      end else begin
         m2_m  = m1_p_ff[46:20] | {26'd0, |m1_p_ff[19:0]};
         m2_in = tts_pkg::fp_round_pack(m1_s_ff, m1_e_ff, m2_m);
      end
      if (m1_spec_ff) m2_in = m1_val_ff;
   end

   assign s_in  = ctrl.bypass ? minuend : fp_sub(minuend, m2_ff);
   assign wdata = ctrl.backward ? s_ff : q;

   always_ff @(posedge clock) begin
      m1_spec_ff <= m1_spec;
      m1_val_ff  <= m1_val;
      m1_p_ff    <= mua.mant * mub.mant;
      m1_e_ff    <= mua.exp + mub.exp - 12'd127;
      m1_s_ff    <= op1[31] ^ op2[31];
      m2_ff      <= m2_in;
      s_ff       <= s_in;
      rd_ff      <= mem[ctrl.addr];
      if (ctrl.wr_en) begin
         mem[ctrl.addr] <= wdata;
         prev_ff        <= wdata;
      end
   end

   tts_fdiv u_fdiv (
      .clock (clock),
      .reset (reset),
      .start (ctrl.div_start),
      .num   (div_num),
      .den   (divisor),
      .done  (div_done),
      .quot  (q)
   );

   assign rd_data = rd_ff;
   assign s_out   = s_ff;

endmodule

>>> rtl/core/tridiagonal_thomas_solver.sv
`timescale 1ns / 1ps
// Tridiagonal solver, Thomas algorithm, IEEE single precision.
// req_*: one row of the system per transaction, row zero first; req_tlast marks the
//   final row. A row that arrives while 64 rows are stored is dropped and flags overflow.
// rsp_*: one solution element per row, row zero first, rsp_tlast on the highest row.
//   rsp_tuser is the overflow flag of the run.
// csr_*: one register at offset 0, bit 0 = rhs_is_complex (0 forces x_imag to zero).
// Timing: after an accepted row the input is not ready while the row passes three
//   multiply/subtract stages and a divider launch, then the iterative divider at two
//   quotient bits a cycle, until the divided row is written. After the last row the
//   backward sweep takes each row through store read, two-stage multiply, subtract and
//   write back, then each result is read from the store and offered only after the
//   previous one was taken.
// Three lanes run side by side: modified super-diagonal, real and imaginary parts;
//   lane zero's pivot feeds all three dividers and the output stage merges the lanes.
// Reset clears the row count, overflow flag, register and handshake state; the stores
//   are not cleared. A stalled result holds in the output register until taken.
module tridiagonal_thomas_solver (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,  // sub_coef, diag_coef, sup_coef, rhs_real, rhs_im
   input  logic         req_tlast,  // last_row
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,  // x_real, x_imag, row_index, 2 zero bits
   output logic         rsp_tuser,  // overflow
   output logic         rsp_tlast,  // last_out
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_F_MUL1 = 4'd1;
   localparam logic [3:0] ST_F_MUL2 = 4'd2;
   localparam logic [3:0] ST_F_SUB  = 4'd3;
   localparam logic [3:0] ST_F_GO   = 4'd4;
   localparam logic [3:0] ST_F_DIV  = 4'd5;
   localparam logic [3:0] ST_B_RD   = 4'd6;
   localparam logic [3:0] ST_B_MUL1 = 4'd7;
   localparam logic [3:0] ST_B_MUL2 = 4'd8;
   localparam logic [3:0] ST_B_SUB  = 4'd9;
   localparam logic [3:0] ST_B_WR   = 4'd10;
   localparam logic [3:0] ST_E_RD   = 4'd11;
   localparam logic [3:0] ST_E_LD   = 4'd12;
   localparam logic [3:0] ST_E_OUT  = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [tts_pkg::ROW_W-1:0]  row_count_ff, row_count_in;
   logic [tts_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic ovf_ff, ovf_in;
   logic cplx_ff;

   logic [31:0] a_ff, b_ff, c_ff, dr_ff, di_ff;
   logic        last_ff;

   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_xr_ff, out_xi_ff;
   logic [5:0]  out_row_ff;
   logic        out_ovf_ff, out_last_ff;

   tts_pkg::lane_ctrl_type ctrl0, ctrl12;
   logic [31:0] lane_rd [3];
   logic [31:0] lane_s  [3];
   logic        lane_done [3];
   logic        done_all, bwd;
   logic        req_acc, rsp_acc, is_last_out;

   assign req_acc     = req_tvalid && req_tready;
   assign rsp_acc     = rsp_tvalid && rsp_tready;
   assign req_tready  = (state_ff == ST_IDLE);
   assign done_all    = lane_done[0] && lane_done[1] && lane_done[2];
   assign bwd         = (state_ff == ST_B_RD) || (state_ff == ST_B_MUL1) ||
                        (state_ff == ST_B_MUL2) || (state_ff == ST_B_SUB) ||
                        (state_ff == ST_B_WR);
   assign is_last_out = (idx_ff == tts_pkg::ADDR_W'(row_count_ff - 7'd1));

   // lane control: forward rows address the fill position, sweeps use idx_ff
   always_comb begin
      ctrl0.backward  = bwd;
      ctrl0.bypass    = (row_count_ff == 7'd0);
      ctrl0.div_start = (state_ff == ST_F_GO);
      ctrl0.wr_en     = (state_ff == ST_F_DIV) && done_all;
      ctrl0.addr      = (state_ff <= ST_F_DIV) ? row_count_ff[tts_pkg::ADDR_W-1:0] : idx_ff;
      ctrl12          = ctrl0;
      ctrl12.bypass   = ctrl0.bypass && !bwd;
      ctrl12.wr_en    = ctrl0.wr_en || (state_ff == ST_B_WR);
   end

   tts_lane u_lane_sup (
      .clock (clock), .reset (reset), .ctrl (ctrl0),
      .mul_x (a_ff), .minuend (b_ff), .div_num (c_ff), .divisor (lane_s[0]),
      .rd_data (lane_rd[0]), .s_out (lane_s[0]),
      .div_done (lane_done[0])
   );

   tts_lane u_lane_re (
      .clock (clock), .reset (reset), .ctrl (ctrl12),
      .mul_x (bwd ? lane_rd[0] : a_ff), .minuend (bwd ? lane_rd[1] : dr_ff),
      .div_num (lane_s[1]), .divisor (lane_s[0]),
      .rd_data (lane_rd[1]), .s_out (lane_s[1]),
      .div_done (lane_done[1])
   );

   tts_lane u_lane_im (
      .clock (clock), .reset (reset), .ctrl (ctrl12),
      .mul_x (bwd ? lane_rd[0] : a_ff), .minuend (bwd ? lane_rd[2] : di_ff),
      .div_num (lane_s[2]), .divisor (lane_s[0]),
      .rd_data (lane_rd[2]), .s_out (lane_s[2]),
      .div_done (lane_done[2])
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      row_count_in = row_count_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      out_valid_in = out_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (row_count_ff < 7'(tts_pkg::MAX_ROWS)) begin
                  state_in = ST_F_MUL1;
               end else begin
                  // dropped row; a last one still closes the run
                  ovf_in = 1'b1;
                  if (req_tlast) begin
                     if (row_count_ff == 7'd1) begin
                        state_in = ST_E_RD;
                        idx_in   = '0;
                     end else begin
                        state_in = ST_B_RD;
                        idx_in   = tts_pkg::ADDR_W'(row_count_ff - 7'd2);
                     end
                  end
               end
            end
         end
         ST_F_MUL1: state_in = ST_F_MUL2;
         ST_F_MUL2: state_in = ST_F_SUB;
         ST_F_SUB:  state_in = ST_F_GO;
         ST_F_GO:   state_in = ST_F_DIV;
         ST_F_DIV: begin
            if (done_all) begin
               row_count_in = row_count_ff + 7'd1;
               if (!last_ff) begin
                  state_in = ST_IDLE;
               end else if (row_count_ff == 7'd0) begin
                  state_in = ST_E_RD;
                  idx_in   = '0;
               end else begin
                  state_in = ST_B_RD;
                  idx_in   = tts_pkg::ADDR_W'(row_count_ff - 7'd1);
               end
            end
         end
         ST_B_RD:   state_in = ST_B_MUL1;
         ST_B_MUL1: state_in = ST_B_MUL2;
         ST_B_MUL2: state_in = ST_B_SUB;
         ST_B_SUB:  state_in = ST_B_WR;
         ST_B_WR: begin
            if (idx_ff == '0) begin
               state_in = ST_E_RD;
            end else begin
               state_in = ST_B_RD;
               idx_in   = idx_ff - 1'b1;
            end
         end
         ST_E_RD: state_in = ST_E_LD;
         ST_E_LD: begin
            state_in     = ST_E_OUT;
            out_valid_in = 1'b1;
         end
         ST_E_OUT: begin
            if (rsp_acc) begin
               out_valid_in = 1'b0;
               if (out_last_ff) begin
                  state_in     = ST_IDLE;
                  row_count_in = '0;
                  ovf_in       = 1'b0;
               end else begin
                  state_in = ST_E_RD;
                  idx_in   = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_count_ff <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         cplx_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) cplx_ff <= csr_pwdata[0];
      end
   end

   // input capture and merged output register
   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_ff    <= req_tdata[31:0];
         b_ff    <= req_tdata[63:32];
         c_ff    <= req_tdata[95:64];
         dr_ff   <= req_tdata[127:96];
         di_ff   <= req_tdata[159:128];
         last_ff <= req_tlast;
      end
      if (state_ff == ST_E_LD) begin
         out_xr_ff   <= lane_rd[1];
         out_xi_ff   <= cplx_ff ? lane_rd[2] : 32'd0;
         out_row_ff  <= idx_ff;
         out_ovf_ff  <= ovf_ff;
         out_last_ff <= is_last_out;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_row_ff, out_xi_ff, out_xr_ff};
   assign rsp_tuser  = out_ovf_ff;
   assign rsp_tlast  = out_last_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = {31'd0, cplx_ff};

   // offset bits are ignored; every offset reaches the single register
   logic unused_addr;
   assign unused_addr = ^csr_paddr;

endmodule

>>> rtl/core/tts_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        rsp_tlast
);

   // rows are not taken while a solution is being emitted
   `ASSERT_NEVER(a_no_overlap, clock, reset, req_tready && rsp_tvalid, "input ready during emission")

   // a result that is not the last keeps the input closed
   `ASSERT_NEXT(a_run_open, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, !req_tready, "input reopened mid-run")

   // the last result of a run frees the input in the next cycle
   `ASSERT_NEXT(a_run_close, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, req_tready, "input not reopened after run")

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   logic unused_in;
   assign unused_in = req_tvalid ^ req_tlast;

endmodule

bind tridiagonal_thomas_solver tts_checker u_tts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

// Tridiagonal solver testbench: rows go in as req transactions, solution
// elements come back as rsp transactions and are checked field by field
// against an in-bench single-precision model of the Thomas sweep.
module testbench;

   // row transaction as the bench sees it
   typedef struct {
      logic [31:0] sub_c;
      logic [31:0] diag_c;
      logic [31:0] sup_c;
      logic [31:0] rhs_re;
      logic [31:0] rhs_im;
      logic        last;
   } row_type;

   // one solution element
   typedef struct {
      logic [31:0] x_re;
      logic [31:0] x_im;
      logic [5:0]  row;
      logic        ovf;
      logic        last;
   } soln_type;

   localparam logic [1:0] REG_RHS_IS_COMPLEX = 2'd0;
   localparam int         CYCLE_LIMIT        = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;  // sub_coef, diag_coef, sup_coef, rhs_real, rhs_im
   logic         req_tlast = 1'b0;  // last_row
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;  // x_real, x_imag, row_index, 2 zero bits
   logic         rsp_tuser;  // overflow
   logic         rsp_tlast;  // last_out
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [1:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   tridiagonal_thomas_solver dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Single-precision arithmetic via doubles. Products of singles are
   // exact in double; add/sub/div double-rounded through double are
   // still correctly rounded since 53 >= 2*24+2.
   // ---------------------------------------------------------------
   function automatic real sp_to_real(logic [31:0] v);
      logic [63:0] d;
      int          p;
      if (v[30:23] == 8'hFF) begin
         d = {v[31], 11'h7FF, v[22:0], 29'd0};
      end else if (v[30:23] == 8'd0) begin
         if (v[22:0] == 23'd0) begin
            d = {v[31], 63'd0};
         end else begin
            p = 0;
            for (int i = 0; i < 23; i++) if (v[i]) p = i;
            d = {v[31], 11'(p - 149 + 1023), 52'({29'd0, v[22:0]} << (52 - p))};
         end
      end else begin
         d = {v[31], 11'({3'd0, v[30:23]} + 11'd896), v[22:0], 29'd0};
      end
      return $bitstoreal(d);
   endfunction

   function automatic logic [31:0] real_to_sp(real r);
      logic [63:0] d, m, q, mag;
      int          es, sh;
      logic        half, sticky;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF)
         return (d[51:0] != 0) ? {d[63], 8'hFF, 1'b1, d[50:29]} : {d[63], 8'hFF, 23'd0};
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      es = int'(d[62:52]) - 1023 + 127;
      m  = {11'd0, 1'b1, d[51:0]};
      sh = (es >= 1) ? 29 : 29 + 1 - es;
      if (sh > 55) return {d[63], 31'd0};
      q      = m >> sh;
      half   = m[sh-1];
      sticky = |(m & ((64'd1 << (sh - 1)) - 64'd1));
      if (half && (sticky || q[0])) q = q + 64'd1;
      mag = (es >= 1) ? ((64'(es - 1) << 23) + q) : q;
      if (mag >= 64'h7F80_0000) mag = 64'h7F80_0000;
      return {d[63], mag[30:0]};
   endfunction

   function automatic logic is_nan(logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   function automatic logic is_zero(logic [31:0] v);
      return v[30:0] == 31'd0;
   endfunction

   function automatic logic [31:0] sp_mul(logic [31:0] a, logic [31:0] b);
      return real_to_sp(sp_to_real(a) * sp_to_real(b));
   endfunction

   function automatic logic [31:0] sp_sub(logic [31:0] a, logic [31:0] b);
      return real_to_sp(sp_to_real(a) - sp_to_real(b));
   endfunction

   // zero divisor handled here so the simulator's real divide never sees it
   function automatic logic [31:0] sp_div(logic [31:0] a, logic [31:0] b);
      if (is_zero(b)) begin
         if (is_zero(a) || is_nan(a)) return 32'hFFC0_0000;
         return {a[31] ^ b[31], 8'hFF, 23'd0};
      end
      return real_to_sp(sp_to_real(a) / sp_to_real(b));
   endfunction

   // ---------------------------------------------------------------
   // Solver model state: forward-sweep stores, row count, overflow,
   // and the rhs_is_complex register.
   // ---------------------------------------------------------------
   logic [31:0] fwd_sup[64];
   logic [31:0] fwd_re[64];
   logic [31:0] fwd_im[64];
   int          rows_held;
   logic        rows_dropped;
   logic        complex_rhs;

   row_type  row_q[$];      // rows waiting for the driver
   soln_type soln_q[$];     // solution elements not yet seen
   int       error_count;

   // forward sweep for one row; on the last row, run the backward sweep
   // and queue the solution elements
   task automatic solve_row(row_type r);
      logic [31:0] piv, nr, ni;
      logic [31:0] xr[64];
      logic [31:0] xi[64];
      soln_type    s;
      if (rows_held < 64) begin
         if (rows_held == 0) begin
            piv = r.diag_c;
            nr  = r.rhs_re;
            ni  = r.rhs_im;
         end else begin
            piv = sp_sub(r.diag_c, sp_mul(fwd_sup[rows_held-1], r.sub_c));
            nr  = sp_sub(r.rhs_re, sp_mul(fwd_re[rows_held-1], r.sub_c));
            ni  = sp_sub(r.rhs_im, sp_mul(fwd_im[rows_held-1], r.sub_c));
         end
         fwd_sup[rows_held] = sp_div(r.sup_c, piv);
         fwd_re[rows_held]  = sp_div(nr, piv);
         fwd_im[rows_held]  = sp_div(ni, piv);
         rows_held++;
      end else begin
         rows_dropped = 1'b1;
      end
      if (!r.last) return;
      if (rows_held > 0) begin
         xr[rows_held-1] = fwd_re[rows_held-1];
         xi[rows_held-1] = fwd_im[rows_held-1];
         for (int i = rows_held - 2; i >= 0; i--) begin
            xr[i] = sp_sub(fwd_re[i], sp_mul(fwd_sup[i], xr[i+1]));
            xi[i] = sp_sub(fwd_im[i], sp_mul(fwd_sup[i], xi[i+1]));
         end
         for (int k = 0; k < rows_held; k++) begin
            s.x_re = xr[k];
            s.x_im = complex_rhs ? xi[k] : 32'd0;
            s.row  = 6'(k);
            s.ovf  = rows_dropped;
            s.last = (k == rows_held - 1);
            soln_q.push_back(s);
         end
      end
      rows_held    = 0;
      rows_dropped = 1'b0;
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
   endtask

   // ---------------------------------------------------------------
   // Driver: bursts of rows with random gaps. valid holds until taken.
   // ---------------------------------------------------------------
   logic req_fire;
   int   burst_left;
   int   gap_left;
   int   cycle_count;

   always @(posedge clock) req_fire <= req_tvalid && req_tready;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 3;
         gap_left   <= 0;
      end else if (!(req_tvalid && !req_fire)) begin
         if (req_fire) void'(row_q.pop_front());
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (row_q.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {row_q[0].rhs_im, row_q[0].rhs_re, row_q[0].sup_c,
                           row_q[0].diag_c, row_q[0].sub_c};
            req_tlast  <= row_q[0].last;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 8);
               // gaps of 0 give stretches with no idling at all
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern: switches mode at random between always
   // ready, random coin flips, and long stalls.
   int stall_mode;
   int stall_run;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_mode <= 0;
         stall_run  <= 0;
      end else begin
         if (cycle_count % 128 == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: begin
               if (stall_run > 0) begin
                  stall_run  <= stall_run - 1;
                  rsp_tready <= 1'b0;
               end else begin
                  stall_run  <= $urandom_range(0, 30);
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Monitor: compare every accepted solution element with the oldest
   // expectation. NaN matches any NaN; the payload is not pinned down.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      soln_type w;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout");
         $display("DONE: errors detected");
         $finish;
      end else if (!reset && rsp_tvalid && rsp_tready) begin
         if (soln_q.size() == 0) begin
            report("unexpected element", rsp_tdata[63:0], 64'd0);
         end else begin
            w = soln_q.pop_front();
            if (rsp_tdata[31:0] !== w.x_re && !(is_nan(rsp_tdata[31:0]) && is_nan(w.x_re)))
               report("x_real", 64'(rsp_tdata[31:0]), 64'(w.x_re));
            if (rsp_tdata[63:32] !== w.x_im && !(is_nan(rsp_tdata[63:32]) && is_nan(w.x_im)))
               report("x_imag", 64'(rsp_tdata[63:32]), 64'(w.x_im));
            if (rsp_tdata[69:64] !== w.row)
               report("row_index", 64'(rsp_tdata[69:64]), 64'(w.row));
            if (rsp_tuser !== w.ovf) report("overflow", 64'(rsp_tuser), 64'(w.ovf));
            if (rsp_tlast !== w.last) report("last_out", 64'(rsp_tlast), 64'(w.last));
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic csr_write(logic [1:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == REG_RHS_IS_COMPLEX) complex_rhs = data[0];
   endtask

   // sender holds off until every expected element is back, then settles
   task automatic drain();
      while (row_q.size() != 0 || req_tvalid || soln_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic push_row(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] dr, logic [31:0] di, logic last);
      row_type r;
      r = '{a, b, c, dr, di, last};
      solve_row(r);
      row_q.push_back(r);
   endtask

   // mostly tame values so systems stay finite, some raw bit patterns
   function automatic logic [31:0] rand_val(int lo_exp, int hi_exp);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return $urandom;
      if (pick == 1) return {1'($urandom), 31'd0};
      return {1'($urandom), 8'($urandom_range(lo_exp, hi_exp)), 23'($urandom)};
   endfunction

   task automatic push_system(int n);
      for (int i = 0; i < n; i++)
         push_row(rand_val(118, 128), rand_val(130, 134), rand_val(118, 128),
                  rand_val(110, 140), rand_val(110, 140), i == n - 1);
   endtask

   int sent;
   int n_rows;

   initial begin
      error_count  = 0;
      cycle_count  = 0;
      rows_held    = 0;
      rows_dropped = 1'b0;
      complex_rhs  = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // one-row systems x = d/b across the special operands
      csr_write(REG_RHS_IS_COMPLEX, 32'd1);
      push_row(32'h0, 32'h3F80_0000, 32'h0, 32'h3F80_0000, 32'hBF80_0000, 1'b1);
      push_row(32'h0, 32'h0000_0000, 32'h0, 32'h3F80_0000, 32'h8000_0000, 1'b1); // d/0
      push_row(32'h0, 32'h8000_0000, 32'h0, 32'h0000_0000, 32'h4000_0000, 1'b1); // 0/0
      push_row(32'h0, 32'h7F80_0000, 32'h0, 32'h7F80_0000, 32'h3F80_0000, 1'b1); // inf
      push_row(32'h0, 32'h7FC0_0001, 32'h0, 32'h3F80_0000, 32'hFFFF_FFFF, 1'b1); // NaN
      push_row(32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
               32'h7F7F_FFFF, 1'b1);                                 // underflow
      push_row(32'h0, 32'h0000_0001, 32'h0, 32'h7F7F_FFFF, 32'h807F_FFFF, 1'b1); // overflow
      // two rows with a zero second pivot
      push_row(32'h0, 32'h3F80_0000, 32'h3F80_0000, 32'h4000_0000, 32'h0, 1'b0);
      push_row(32'h3F80_0000, 32'h3F80_0000, 32'hFFFF_FFFF, 32'h4040_0000,
               32'h3F80_0000, 1'b1);
      push_system(3);
      drain();

      // full store, then a run that overflows, with the last mark on a dropped row
      csr_write(REG_RHS_IS_COMPLEX, 32'd0);
      push_system(64);
      push_system(66);
      drain();
      // overflow run whose last row is the first one dropped
      csr_write(REG_RHS_IS_COMPLEX, 32'hFFFF_FFFF);
      push_system(65);
      drain();

      // random systems, mostly short, register set at random between phases
      sent = 0;
      while (sent < 190) begin
         csr_write(REG_RHS_IS_COMPLEX, {31'd0, 1'($urandom)});
         for (int k = 0; k < 6; k++) begin
            n_rows = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                 : $urandom_range(1, 6);
            push_system(n_rows);
            sent += n_rows;
         end
         drain();
      end

      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> tridiagonal_thomas_solver.f
+incdir+rtl/core
rtl/core/tts_pkg.sv
rtl/core/tts_fdiv.sv
rtl/core/tts_lane.sv
rtl/core/tridiagonal_thomas_solver.sv
rtl/core/tts_checker.sv
tb/testbench.sv
